// ===== rtl/value_noise_3d_sampler_unit_assert.svh =====
// value_noise_3d_sampler_unit_assert.svh
// Assertion macros used by the noise sampler checker. No dependencies.
`ifndef VALUE_NOISE_3D_SAMPLER_UNIT_ASSERT_SVH
`define VALUE_NOISE_3D_SAMPLER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define VN3_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define VN3_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vn3_pkg.sv =====
// vn3_pkg.sv
// Shared widths, function codes and control types of the value noise sampler.
// No dependencies.
`default_nettype none

package vn3_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned LOAD_W  = 16;
  localparam int unsigned PERM_W  = 8;
  localparam int unsigned NOISE_W = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE     = 2'd0,
    FUNC_LOAD_PERM  = 2'd1,
    FUNC_LOAD_VALUE = 2'd2
  } func_e;

  typedef struct packed {
    logic mul_en;
    logic add_en;
  } lerp_en_t;

endpackage

`default_nettype wire

// ===== rtl/vn3_ram2r.sv =====
// vn3_ram2r.sv
// Table memory with one write port and two registered read ports.
// No dependencies.
`default_nettype none

module vn3_ram2r #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned DW    = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [DW-1:0]            rdata0_o,
  output logic      [DW-1:0]            rdata1_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata0_q;
  logic [DW-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

`default_nettype wire

// ===== rtl/vn3_lerp.sv =====
// vn3_lerp.sv
// Two-stage linear blend a + floor(t * (b - a) / 2^FB): multiply, then add.
// Depends on vn3_pkg.
`default_nettype none

module vn3_lerp
  import vn3_pkg::*;
#(
  parameter int unsigned FB = 16,
  parameter int unsigned VB = 16
) (
  input  wire logic          clk_i,
  input  wire lerp_en_t      en_i,
  input  wire logic [FB-1:0] t_i,
  input  wire logic [VB-1:0] a_i,
  input  wire logic [VB-1:0] b_i,
  output logic      [VB-1:0] y_o
);

  localparam int unsigned PW = FB + VB + 2;

  logic signed [VB:0]   diff;
  logic signed [PW-1:0] prod_d;
  logic signed [PW-1:0] prod_q;
  logic        [VB-1:0] a_q;
  logic signed [VB:0]   step;
  logic        [VB:0]   sum;
  logic        [VB-1:0] y_d;
  logic        [VB-1:0] y_q;

  always_comb begin
    diff   = $signed({1'b0, b_i}) - $signed({1'b0, a_i});
    prod_d = $signed({1'b0, t_i}) * diff;
  end

  // The arithmetic shift floors toward minus infinity, so the result
  // always lies between a and b.
  always_comb begin
    step = (VB + 1)'(prod_q >>> FB);
    sum  = {1'b0, a_q} + step;
    y_d  = sum[VB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
    if (en_i.add_en) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

// ===== rtl/value_noise_3d_sampler_unit.sv =====
// value_noise_3d_sampler_unit: 3D lattice value noise with trilinear blend.
// Each accepted sample word passes the registered stages ST_IN to ST_OUT to
// its result word; one word is accepted per cycle while the output is not
// stalled, as replicated table copies serve all corner lookups of a stage at once.
// Reset clears the stage valid bits only; both tables keep their contents
// and must be loaded before they are sampled. Depends on vn3_pkg.
`default_nettype none

module value_noise_3d_sampler_unit
  import vn3_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 256,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [FUNC_W-1:0]  func_i,
  input  wire logic [COORD_W-1:0] coord_x_i,
  input  wire logic [COORD_W-1:0] coord_y_i,
  input  wire logic [COORD_W-1:0] coord_z_i,
  input  wire logic [INDEX_W-1:0] load_index_i,
  input  wire logic [LOAD_W-1:0]  load_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [NOISE_W-1:0] noise_o
);

  // The user must keep TABLE_SIZE a power of two; the block does not enforce it. Every wrap is then a truncation.
  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned NS = 11;

  localparam int unsigned ST_IN   = 0;
  localparam int unsigned ST_ZH   = 1;
  localparam int unsigned ST_YH   = 2;
  localparam int unsigned ST_XH   = 3;
  localparam int unsigned ST_VAL  = 4;
  localparam int unsigned ST_XMUL = 5;
  localparam int unsigned ST_XSUM = 6;
  localparam int unsigned ST_YMUL = 7;
  localparam int unsigned ST_YSUM = 8;
  localparam int unsigned ST_ZMUL = 9;
  localparam int unsigned ST_OUT  = 10;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [PERM_W-1:0] h);
    wrap_add = base + IW'(h);
  endfunction

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_d;
  logic [NS:0]   en;

  func_e                func_q [ST_XH+1];
  logic [IW-1:0]        lidx_q [ST_XH+1];
  logic [LOAD_W-1:0]    lval_q [ST_XH+1];
  logic [IW-1:0]        ix_q   [ST_YH+1];
  logic [IW-1:0]        iy_q   [ST_ZH+1];
  logic [IW-1:0]        iz_q;
  logic [FRAC_BITS-1:0] tx_q   [ST_VAL+1];
  logic [FRAC_BITS-1:0] ty_q   [ST_XSUM+1];
  logic [FRAC_BITS-1:0] tz_q   [ST_YSUM+1];

  logic [IW-1:0]         iz_inc;
  logic [IW-1:0]         iy_inc;
  logic [IW-1:0]         ix_inc;
  logic [PERM_W-1:0]     zh [2];
  logic [PERM_W-1:0]     yh [4];
  logic [PERM_W-1:0]     xh [4][2];
  logic [VALUE_BITS-1:0] val [4][2];
  logic [VALUE_BITS-1:0] row [4];
  logic [VALUE_BITS-1:0] plane [2];
  logic [VALUE_BITS-1:0] res;

  logic perm1_we;
  logic perm2_we;
  logic perm3_we;
  logic value_we;

  always_comb begin
    v_d[ST_IN] = in_valid_i;
    for (int s = 1; s < NS; s++) begin
      v_d[s] = v_q[s-1];
    end
    // Only sample words go on past the last table write.
    v_d[ST_VAL] = v_q[ST_XH] && (func_q[ST_XH] == FUNC_SAMPLE);
  end

  always_comb begin
    en[NS] = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_ready_o  = en[ST_IN];
  assign out_valid_o = v_q[ST_OUT];
  assign noise_o     = NOISE_W'(res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (en[s]) begin
          v_q[s] <= v_d[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      func_q[ST_IN] <= func_e'(func_i);
      lidx_q[ST_IN] <= IW'(load_index_i);
      lval_q[ST_IN] <= load_value_i;
      ix_q[ST_IN]   <= IW'(coord_x_i >> FRAC_BITS);
      iy_q[ST_IN]   <= IW'(coord_y_i >> FRAC_BITS);
      iz_q          <= IW'(coord_z_i >> FRAC_BITS);
      tx_q[ST_IN]   <= coord_x_i[FRAC_BITS-1:0];
      ty_q[ST_IN]   <= coord_y_i[FRAC_BITS-1:0];
      tz_q[ST_IN]   <= coord_z_i[FRAC_BITS-1:0];
    end
    for (int s = 1; s <= ST_XH; s++) begin
      if (en[s]) begin
        func_q[s] <= func_q[s-1];
        lidx_q[s] <= lidx_q[s-1];
        lval_q[s] <= lval_q[s-1];
      end
    end
    for (int s = 1; s <= ST_YH; s++) begin
      if (en[s]) begin
        ix_q[s] <= ix_q[s-1];
      end
    end
    if (en[ST_ZH]) begin
      iy_q[ST_ZH] <= iy_q[ST_IN];
    end
    for (int s = 1; s <= ST_VAL; s++) begin
      if (en[s]) begin
        tx_q[s] <= tx_q[s-1];
      end
    end
    for (int s = 1; s <= ST_XSUM; s++) begin
      if (en[s]) begin
        ty_q[s] <= ty_q[s-1];
      end
    end
    for (int s = 1; s <= ST_YSUM; s++) begin
      if (en[s]) begin
        tz_q[s] <= tz_q[s-1];
      end
    end
  end

  // Each table copy is written as a load word passes the stage that reads
  // it, so every sample sees exactly the loads that came before it.
  always_comb begin
    perm1_we = en[ST_ZH] && v_q[ST_IN] && (func_q[ST_IN] == FUNC_LOAD_PERM);
    perm2_we = en[ST_YH] && v_q[ST_ZH] && (func_q[ST_ZH] == FUNC_LOAD_PERM);
    perm3_we = en[ST_XH] && v_q[ST_YH] && (func_q[ST_YH] == FUNC_LOAD_PERM);
    value_we = en[ST_VAL] && v_q[ST_XH] && (func_q[ST_XH] == FUNC_LOAD_VALUE);
    iz_inc   = iz_q + IW'(1);
    iy_inc   = iy_q[ST_ZH] + IW'(1);
    ix_inc   = ix_q[ST_YH] + IW'(1);
  end

  vn3_ram2r #(
    .DEPTH(TABLE_SIZE),
    .DW   (PERM_W)
  ) u_perm_z (
    .clk_i   (clk_i),
    .we_i    (perm1_we),
    .waddr_i (lidx_q[ST_IN]),
    .wdata_i (lval_q[ST_IN][PERM_W-1:0]),
    .re_i    (en[ST_ZH]),
    .raddr0_i(iz_q),
    .raddr1_i(iz_inc),
    .rdata0_o(zh[0]),
    .rdata1_o(zh[1])
  );

  for (genvar dz = 0; dz < 2; dz++) begin : g_perm_y
    vn3_ram2r #(
      .DEPTH(TABLE_SIZE),
      .DW   (PERM_W)
    ) u_perm_y (
      .clk_i   (clk_i),
      .we_i    (perm2_we),
      .waddr_i (lidx_q[ST_ZH]),
      .wdata_i (lval_q[ST_ZH][PERM_W-1:0]),
      .re_i    (en[ST_YH]),
      .raddr0_i(wrap_add(iy_q[ST_ZH], zh[dz])),
      .raddr1_i(wrap_add(iy_inc, zh[dz])),
      .rdata0_o(yh[dz*2]),
      .rdata1_o(yh[dz*2+1])
    );
  end

  for (genvar c = 0; c < 4; c++) begin : g_corner
    vn3_ram2r #(
      .DEPTH(TABLE_SIZE),
      .DW   (PERM_W)
    ) u_perm_x (
      .clk_i   (clk_i),
      .we_i    (perm3_we),
      .waddr_i (lidx_q[ST_YH]),
      .wdata_i (lval_q[ST_YH][PERM_W-1:0]),
      .re_i    (en[ST_XH]),
      .raddr0_i(wrap_add(ix_q[ST_YH], yh[c])),
      .raddr1_i(wrap_add(ix_inc, yh[c])),
      .rdata0_o(xh[c][0]),
      .rdata1_o(xh[c][1])
    );

    vn3_ram2r #(
      .DEPTH(TABLE_SIZE),
      .DW   (VALUE_BITS)
    ) u_value (
      .clk_i   (clk_i),
      .we_i    (value_we),
      .waddr_i (lidx_q[ST_XH]),
      .wdata_i (VALUE_BITS'(lval_q[ST_XH])),
      .re_i    (en[ST_VAL]),
      .raddr0_i(IW'(xh[c][0])),
      .raddr1_i(IW'(xh[c][1])),
      .rdata0_o(val[c][0]),
      .rdata1_o(val[c][1])
    );

    vn3_lerp #(
      .FB(FRAC_BITS),
      .VB(VALUE_BITS)
    ) u_lerp_x (
      .clk_i(clk_i),
      .en_i ('{mul_en: en[ST_XMUL], add_en: en[ST_XSUM]}),
      .t_i  (tx_q[ST_VAL]),
      .a_i  (val[c][0]),
      .b_i  (val[c][1]),
      .y_o  (row[c])
    );
  end

  for (genvar dz = 0; dz < 2; dz++) begin : g_plane
    vn3_lerp #(
      .FB(FRAC_BITS),
      .VB(VALUE_BITS)
    ) u_lerp_y (
      .clk_i(clk_i),
      .en_i ('{mul_en: en[ST_YMUL], add_en: en[ST_YSUM]}),
      .t_i  (ty_q[ST_XSUM]),
      .a_i  (row[dz*2]),
      .b_i  (row[dz*2+1]),
      .y_o  (plane[dz])
    );
  end

  vn3_lerp #(
    .FB(FRAC_BITS),
    .VB(VALUE_BITS)
  ) u_lerp_z (
    .clk_i(clk_i),
    .en_i ('{mul_en: en[ST_ZMUL], add_en: en[ST_OUT]}),
    .t_i  (tz_q[ST_YSUM]),
    .a_i  (plane[0]),
    .b_i  (plane[1]),
    .y_o  (res)
  );

endmodule

`default_nettype wire

// ===== rtl/vn3_checker.sv =====
// vn3_checker.sv
// Port-level checks of the noise sampler and the bind that attaches them.
// Depends on vn3_pkg, value_noise_3d_sampler_unit_assert.svh and the top level.
`default_nettype none

`include "value_noise_3d_sampler_unit_assert.svh"

module vn3_checker
  import vn3_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [NOISE_W-1:0] noise_o
);

  // A stalled result word stays on the port unchanged.
  `VN3_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(noise_o), "result word changed while stalled")

  // With the output free to move, no stage can block the input.
  `VN3_ASSERT(a_in_ready, clk_i, rst_ni, (!out_valid_o || out_ready_i) |-> in_ready_o, "input blocked while output can drain")

  // With no new word and a free output, the pipeline empties within its depth.
  `VN3_ASSERT(a_no_bypass, clk_i, rst_ni, (!in_valid_i && out_ready_i) [*11] |=> !out_valid_o, "result appeared without an earlier word")

  // Reset empties the pipeline.
  `VN3_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind value_noise_3d_sampler_unit vn3_checker u_vn3_checker (.*);

`default_nettype wire
